@@ design/tcm_pkg.sv @@
// Package with shared constants, types and helpers for the thruster command mixer.
`timescale 1ns / 1ps
`default_nettype none
package tcm_pkg;

  localparam int unsigned NumThrusters = 5;
  localparam int unsigned PulseW       = 11;
  localparam int unsigned WordW        = 30;
  localparam int unsigned Quot1W       = 21;
  localparam int unsigned Quot2W       = 11;
  localparam int unsigned RemW         = 10;
  localparam int unsigned SpeedW       = 7;
  localparam int unsigned DeltaW       = 9;
  localparam int unsigned OutDataW     = 72;
  localparam int unsigned CfgW         = 16;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [PulseW-1:0]  StopUs    = 11'd1500;
  localparam logic [WordW-1:0]   ArmLevel  = 30'd100000000;
  localparam logic [SpeedW-1:0]  SpeedMax  = 7'd99;
  localparam logic [15:0]        Recip99   = 16'd42367;  // 2^22 / 99, rounded up
  localparam int unsigned        Recip99Sh = 22;
  localparam logic [12:0]        Recip100  = 13'd5243;   // 2^19 / 100, rounded up
  localparam int unsigned        Recip100Sh = 19;
  localparam logic [RemW-1:0]    Thousand  = 10'd1000;
  localparam logic [30:0]        Recip1kA  = 31'd1099511628;  // 2^40 / 1000, rounded up
  localparam int unsigned        Recip1kASh = 40;
  localparam logic [21:0]        Recip1kB  = 22'd2147484;     // 2^31 / 1000, rounded up
  localparam int unsigned        Recip1kBSh = 31;
  localparam logic [10:0]        Recip100D = 11'd1311;        // 2^17 / 100, rounded up
  localparam int unsigned        Recip100DSh = 17;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLiftSpeed = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLightLvl  = 2'd2;

  // Direction and command digit codes
  localparam logic [3:0] DirNone  = 4'd0;
  localparam logic [3:0] DirFwdHr = 4'd1;
  localparam logic [3:0] DirFwd   = 4'd2;
  localparam logic [3:0] DirFwdHl = 4'd3;
  localparam logic [3:0] DirSpinR = 4'd4;
  localparam logic [3:0] DirStop  = 4'd5;
  localparam logic [3:0] DirSpinL = 4'd6;
  localparam logic [3:0] DirRevHl = 4'd7;
  localparam logic [3:0] DirRev   = 4'd8;
  localparam logic [3:0] DirRevHr = 4'd9;
  localparam logic [3:0] CmdLight = 4'd1;
  localparam logic [3:0] CmdTune  = 4'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic split_a;
    logic split_b;
    logic split_c;
    logic decode;
    logic tune;
    logic scale;
    logic delta;
    logic update;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op;
    logic out_free;
  } dp_stat_t;

  // Scale a speed of 0..99 to a pulse offset of speed*400/99
  function automatic logic [DeltaW-1:0] speed_delta(input logic [SpeedW-1:0] s);
    logic [15:0] y;
    logic [31:0] p;
    begin
      y = 16'({s, 8'b0}) + 16'({s, 7'b0}) + 16'({s, 4'b0});
      p = 32'(y) * 32'(Recip99);
      speed_delta = p[Recip99Sh +: DeltaW];
    end
  endfunction

  // Map a light value of 0..99 to duty value*255/99
  function automatic logic [7:0] light_map(input logic [SpeedW-1:0] v);
    logic [15:0] y;
    logic [31:0] p;
    begin
      y = 16'({v, 8'b0}) - 16'(v);
      p = 32'(y) * 32'(Recip99);
      light_map = p[Recip99Sh +: 8];
    end
  endfunction

  // Hundreds of a value below 1100
  function automatic logic [3:0] hundreds(input logic [10:0] x);
    logic [21:0] p;
    begin
      p = 22'(x) * 22'(Recip100D);
      hundreds = p[Recip100DSh +: 4];
    end
  endfunction

  // Remainder of x after taking away h hundreds
  function automatic logic [SpeedW-1:0] rem100(input logic [10:0] x, input logic [3:0] h);
    logic [10:0] r;
    begin
      r = x - 11'({h, 6'b0}) - 11'({h, 5'b0}) - 11'({h, 2'b0});
      rem100 = r[SpeedW-1:0];
    end
  endfunction

  // Saturate a 7-bit value to 99
  function automatic logic [SpeedW-1:0] sat99(input logic [SpeedW-1:0] v);
    sat99 = (v > SpeedMax) ? SpeedMax : v;
  endfunction

endpackage
`default_nettype wire

@@ design/tcm_ctrl.sv @@
// Sequencer for the thruster command mixer: steps the datapath through one request.
`timescale 1ns / 1ps
`default_nettype none
module tcm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire tcm_pkg::dp_stat_t stat_i,
  output tcm_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StSplitA, StSplitB, StSplitC, StDecode, StTune, StScale, StDelta, StUpdate
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = stat_i.op ? StDecode : StSplitA;
      end
      StSplitA: state_d = StSplitB;
      StSplitB: state_d = StSplitC;
      StSplitC: state_d = StDecode;
      StDecode: state_d = StTune;
      StTune:   state_d = StScale;
      StScale:  state_d = StDelta;
      StDelta:  state_d = StUpdate;
      StUpdate: if (stat_i.out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode commands
  assign in_ready_o     = (state_q == StIdle);
  assign cmd_o.load     = (state_q == StIdle) && in_valid_i;
  assign cmd_o.split_a  = (state_q == StSplitA);
  assign cmd_o.split_b  = (state_q == StSplitB);
  assign cmd_o.split_c  = (state_q == StSplitC);
  assign cmd_o.decode   = (state_q == StDecode);
  assign cmd_o.tune     = (state_q == StTune);
  assign cmd_o.scale    = (state_q == StScale);
  assign cmd_o.delta    = (state_q == StDelta);
  assign cmd_o.update   = (state_q == StUpdate) && stat_i.out_free;

endmodule
`default_nettype wire

@@ design/tcm_dp.sv @@
// Datapath of the thruster command mixer: digit split, scaling, state and result register.
`timescale 1ns / 1ps
`default_nettype none
module tcm_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tcm_pkg::dp_cmd_t                  cmd_i,
  output tcm_pkg::dp_stat_t                      stat_o,
  input  wire logic                              in_op_i,
  input  wire logic [tcm_pkg::WordW-1:0]         in_word_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [tcm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [tcm_pkg::CfgW-1:0]          cfg_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [tcm_pkg::OutDataW-1:0]           out_data_o
);

  localparam int unsigned PW = tcm_pkg::PulseW;
  localparam int unsigned SW = tcm_pkg::SpeedW;
  localparam int unsigned DW = tcm_pkg::DeltaW;
  localparam int unsigned Q1 = tcm_pkg::Quot1W;
  localparam int unsigned Q2 = tcm_pkg::Quot2W;
  localparam int unsigned RW = tcm_pkg::RemW;

  logic [15:0]   timeout_q, quiet_q;
  logic [SW-1:0] lift_q, lvl_q, tune_q;
  logic          armed_q, op_q, fs_q;
  logic [tcm_pkg::WordW-1:0] bin_q;
  logic [Q1-1:0] q1_q;
  logic [Q2-1:0] q2_q;
  logic [RW-1:0] r1_q, r2_q;
  logic [60:0]   q1_prod;
  logic [42:0]   q2_prod;
  logic [tcm_pkg::WordW-1:0] r1_full;
  logic [Q1-1:0] r2_full;
  logic [3:0]    hq, hv, hc;
  logic [3:0]    hd_q, vd_q, cm_q;
  logic [SW-1:0] hs_q, vs_q, val_q, t_q;
  logic [13:0]   prod_q;
  logic [DW-1:0] dhs_q, dhh_q, dvs_q, dvt_q;
  logic [7:0]    lmap_q, light_q, light_d;
  logic [SW-1:0] tune_d;
  logic [PW-1:0] pw_q [tcm_pkg::NumThrusters];
  logic [PW-1:0] pw_d [tcm_pkg::NumThrusters];
  logic          out_valid_q;
  logic [tcm_pkg::OutDataW-1:0] out_data_q;
  logic [26:0]   tprod;

  assign stat_o.op       = in_op_i;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Split the word by thousands with reciprocal multiplications
  assign q1_prod = 61'(bin_q) * 61'(tcm_pkg::Recip1kA);
  assign q2_prod = 43'(q1_q) * 43'(tcm_pkg::Recip1kB);
  assign r1_full = bin_q - 30'(q1_q) * 30'(tcm_pkg::Thousand);
  assign r2_full = q1_q - 21'(q2_q) * 21'(tcm_pkg::Thousand);

  // Hundreds digit of each three-digit group
  assign hq = tcm_pkg::hundreds(q2_q);
  assign hv = tcm_pkg::hundreds({1'b0, r2_q});
  assign hc = tcm_pkg::hundreds({1'b0, r1_q});

  function automatic logic [PW-1:0] fwd(input logic [DW-1:0] d);
    fwd = tcm_pkg::StopUs + PW'(d);
  endfunction

  function automatic logic [PW-1:0] rev(input logic [DW-1:0] d);
    rev = tcm_pkg::StopUs - PW'(d);
  endfunction

  assign tprod = 27'(prod_q) * 27'(tcm_pkg::Recip100);

  // New thruster, light and tune values from the decoded request
  always_comb begin
    for (int i = 0; i < tcm_pkg::NumThrusters; i++) pw_d[i] = pw_q[i];
    case (hd_q)
      tcm_pkg::DirStop:  begin pw_d[0] = tcm_pkg::StopUs; pw_d[1] = tcm_pkg::StopUs; end
      tcm_pkg::DirFwd:   begin pw_d[0] = fwd(dhs_q); pw_d[1] = fwd(dhs_q); end
      tcm_pkg::DirRev:   begin pw_d[0] = rev(dhs_q); pw_d[1] = rev(dhs_q); end
      tcm_pkg::DirSpinR: begin pw_d[0] = fwd(dhs_q); pw_d[1] = rev(dhs_q); end
      tcm_pkg::DirSpinL: begin pw_d[0] = rev(dhs_q); pw_d[1] = fwd(dhs_q); end
      tcm_pkg::DirRevHl: begin pw_d[0] = rev(dhs_q); pw_d[1] = rev(dhh_q); end
      tcm_pkg::DirRevHr: begin pw_d[0] = rev(dhh_q); pw_d[1] = rev(dhs_q); end
      tcm_pkg::DirFwdHr: begin pw_d[0] = fwd(dhs_q); pw_d[1] = fwd(dhh_q); end
      tcm_pkg::DirFwdHl: begin pw_d[0] = fwd(dhh_q); pw_d[1] = fwd(dhs_q); end
      default: ;
    endcase
    case (vd_q)
      tcm_pkg::DirStop: begin
        pw_d[2] = tcm_pkg::StopUs; pw_d[3] = tcm_pkg::StopUs; pw_d[4] = tcm_pkg::StopUs;
      end
      tcm_pkg::DirFwd: begin
        pw_d[2] = rev(dvt_q); pw_d[3] = rev(dvt_q); pw_d[4] = fwd(dvs_q);
      end
      tcm_pkg::DirRev: begin
        pw_d[2] = fwd(dvt_q); pw_d[3] = fwd(dvt_q); pw_d[4] = rev(dvs_q);
      end
      default: ;
    endcase
    light_d = (cm_q == tcm_pkg::CmdLight) ? lmap_q : light_q;
    tune_d  = (cm_q == tcm_pkg::CmdTune) ? val_q : tune_q;
  end

  // Configuration, control and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= 16'd10000;
      lift_q      <= 7'd60;
      lvl_q       <= 7'd99;
      tune_q      <= 7'd80;
      light_q     <= '0;
      armed_q     <= 1'b0;
      quiet_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < tcm_pkg::NumThrusters; i++) pw_q[i] <= tcm_pkg::StopUs;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tcm_pkg::CfgTimeout:   timeout_q <= cfg_data_i;
          tcm_pkg::CfgLiftSpeed: lift_q    <= cfg_data_i[SW-1:0];
          tcm_pkg::CfgLightLvl:  lvl_q     <= cfg_data_i[SW-1:0];
          default: ;
        endcase
      end
      // Take a request: a command word clears the silence timer and may arm, a tick advances it
      if (cmd_i.load) begin
        if (!in_op_i) begin
          quiet_q <= '0;
          if (in_word_i > tcm_pkg::ArmLevel) armed_q <= 1'b1;
        end else if (quiet_q != 16'hFFFF) begin
          quiet_q <= quiet_q + 16'd1;
        end
      end
      if (cmd_i.update) begin
        for (int i = 0; i < tcm_pkg::NumThrusters; i++) pw_q[i] <= pw_d[i];
        light_q     <= light_d;
        tune_q      <= tune_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of one request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      fs_q  <= in_op_i && armed_q && (quiet_q >= timeout_q);
      bin_q <= in_word_i;
    end
    if (cmd_i.split_a) q1_q <= q1_prod[tcm_pkg::Recip1kASh +: Q1];
    if (cmd_i.split_b) begin
      r1_q <= r1_full[RW-1:0];
      q2_q <= q2_prod[tcm_pkg::Recip1kBSh +: Q2];
    end
    if (cmd_i.split_c) r2_q <= r2_full[RW-1:0];
    // Split digits, or for a tick stand in the failsafe action or no action
    if (cmd_i.decode) begin
      if (!op_q) begin
        hd_q  <= (hq > 4'd9) ? '0 : hq;
        hs_q  <= tcm_pkg::rem100(q2_q, hq);
        vd_q  <= hv;
        vs_q  <= tcm_pkg::rem100({1'b0, r2_q}, hv);
        cm_q  <= hc;
        val_q <= tcm_pkg::rem100({1'b0, r1_q}, hc);
      end else if (fs_q) begin
        hd_q  <= tcm_pkg::DirStop;
        hs_q  <= '0;
        vd_q  <= tcm_pkg::DirFwd;
        vs_q  <= tcm_pkg::sat99(lift_q);
        cm_q  <= tcm_pkg::CmdLight;
        val_q <= tcm_pkg::sat99(lvl_q);
      end else begin
        hd_q  <= tcm_pkg::DirNone;
        hs_q  <= '0;
        vd_q  <= tcm_pkg::DirNone;
        vs_q  <= '0;
        cm_q  <= '0;
        val_q <= '0;
      end
    end
    if (cmd_i.tune)  prod_q <= 14'(vs_q) * 14'(tune_q);
    if (cmd_i.scale) t_q    <= tprod[tcm_pkg::Recip100Sh +: SW];
    if (cmd_i.delta) begin
      dhs_q  <= tcm_pkg::speed_delta(hs_q);
      dhh_q  <= tcm_pkg::speed_delta({1'b0, hs_q[SW-1:1]});
      dvs_q  <= tcm_pkg::speed_delta(vs_q);
      dvt_q  <= tcm_pkg::speed_delta(t_q);
      lmap_q <= tcm_pkg::light_map(val_q);
    end
    if (cmd_i.update) begin
      out_data_q <= {7'b0, armed_q, fs_q, light_d, pw_d[4], pw_d[3], pw_d[2],
                     pw_d[1], pw_d[0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

@@ design/thruster_command_mixer_failsafe.sv @@
// Top level of the thruster command mixer with failsafe.
// Each request is a decimal command word (tuser 0) or a millisecond tick (tuser 1) and
// yields one result with the five pulse widths, light duty and flags. A command word
// goes from acceptance to result through the steps SplitA, SplitB and SplitC, which
// split the word into digits by reciprocal multiplication, then decode, tune, scale,
// delta and update. A tick skips the split. A new request is taken only in the idle
// state, once the update step is done; the update step stalls while the previous result
// still waits in the output register. Configuration writes: index 0 timeout_ms, 1
// failsafe lift speed, 2 failsafe light level; write only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module thruster_command_mixer_failsafe (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [31:0]                   s_axis_tdata_i,  // command_word[29:0]
  input  wire logic                          s_axis_tuser_i,  // op
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // right, left, up_right, up_left, back pulse (11 each), light_duty,
  // failsafe_active, armed_flag, zero fill
  output logic [tcm_pkg::OutDataW-1:0]       m_axis_tdata_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tcm_pkg::CfgW-1:0]      cfg_data_i
);

  tcm_pkg::dp_cmd_t  cmd;
  tcm_pkg::dp_stat_t stat;

  tcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tcm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (s_axis_tuser_i),
    .in_word_i   (s_axis_tdata_i[tcm_pkg::WordW-1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire
